// ----- rtl/ans_pkg.sv -----
`default_nettype none

package ans_pkg;

    // Character codes the scanner reacts to.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_THREE = 8'h33;

    // Reset value of the terminator register (semicolon).
    localparam logic [7:0] TERM_RESET = 8'h3B;

    localparam logic [7:0] RADIX_OCT = 8'd8;
    localparam logic [7:0] RADIX_DEC = 8'd10;

    // Scan phases.
    localparam logic [1:0] PH_START  = 2'd0;
    localparam logic [1:0] PH_SIGN   = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERSIZE = 2'd1;
    localparam logic [1:0] ST_GARBAGE  = 2'd2;

    localparam int CHAR_W   = 8;
    localparam int VALUE_W  = 32;
    localparam int BITCNT_W = 7;
    localparam int STATUS_W = 2;
    localparam int OBITS_W  = 6;

    localparam logic [OBITS_W-1:0] OBITS_SAT   = 6'd63;
    localparam logic [OBITS_W-1:0] OBITS_LIMIT = 6'd60;
    localparam logic [OBITS_W-1:0] OBITS_STEP  = 6'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [BITCNT_W-1:0]       bit_count;
        logic [STATUS_W-1:0]       status;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/ans_char_if.sv -----
`default_nettype none

interface ans_char_if import ans_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/ans_cfg_if.sv -----
`default_nettype none

interface ans_cfg_if import ans_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] terminator_char;

    modport source (output valid, output terminator_char, input ready);
    modport sink (input valid, input terminator_char, output ready);
endinterface

`default_nettype wire

// ----- rtl/ans_result_if.sv -----
`default_nettype none

interface ans_result_if import ans_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic [BITCNT_W-1:0]       bit_count;
    logic [STATUS_W-1:0]       status;

    modport source (output valid, output value, output bit_count, output status, input ready);
    modport sink (input valid, input value, input bit_count, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/ans_in_stage.sv -----
`default_nettype none

module ans_in_stage import ans_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic              i_adv,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic [CHAR_W-1:0]      o_char
);

    logic              r_valid;
    logic              n_valid;
    logic [CHAR_W-1:0] r_char;
    logic              load;

    // The slot frees up in the same cycle that the core consumes it.
    assign o_ready = !r_valid || i_adv;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_char;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;

endmodule

`default_nettype wire

// ----- rtl/ans_scan_core.sv -----
`default_nettype none

module ans_scan_core import ans_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CHAR_W-1:0] i_cfg_term,
    input  wire logic              i_step,
    input  wire logic [CHAR_W-1:0] i_char,
    output logic                   o_emit,
    output t_result                o_result
);

    localparam int MAG_W = VALUE_BITS - 1;
    localparam int EXT_W = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;
    localparam logic [MAG_W-1:0] OCT_LIM = MAG_MAX / 8;
    localparam logic [MAG_W-1:0] DEC_LIM = MAG_MAX / 10;

    logic [CHAR_W-1:0]  r_term;
    logic [1:0]         r_phase,  n_phase;
    logic               r_neg,    n_neg;
    logic               r_octal,  n_octal;
    logic [MAG_W-1:0]   r_mag,    n_mag;
    logic               r_ovf,    n_ovf;
    logic [OBITS_W-1:0] r_obits,  n_obits;

    logic [CHAR_W-1:0]  digit;
    logic [CHAR_W-1:0]  radix;
    logic               is_digit;
    logic [MAG_W+3:0]   mag_scaled;
    logic [MAG_W+3:0]   mag_new;
    logic               in_limit;
    logic [EXT_W-1:0]   mag_ext;
    logic [EXT_W-1:0]   mag_neg;
    logic               bad_term;
    t_result            res;
    logic               emit;

    assign digit    = i_char - CH_ZERO;
    assign radix    = r_octal ? RADIX_OCT : RADIX_DEC;
    assign is_digit = (i_char >= CH_ZERO) && (digit < radix);

    // Multiply by 8 or 10 as shift-and-add.
    assign mag_scaled = r_octal ? {1'b0, r_mag, 3'b000}
                                : ({1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0});
    assign mag_new    = mag_scaled + (MAG_W+4)'(digit);
    assign in_limit   = r_octal ? (r_mag <= OCT_LIM) : (r_mag <= DEC_LIM);

    assign mag_ext  = EXT_W'(r_mag);
    assign mag_neg  = -mag_ext;
    assign bad_term = (r_term != CH_NUL) && (i_char != CH_NUL) && (i_char != r_term);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_octal = r_octal;
        n_mag   = r_mag;
        n_ovf   = r_ovf;
        n_obits = r_obits;
        emit    = 1'b0;
        res     = '0;

        if (r_phase == PH_START && i_char == CH_MINUS) begin
            n_neg   = 1'b1;
            n_phase = PH_SIGN;
        end else if (r_phase != PH_DIGITS && i_char == CH_ZERO) begin
            // A leading zero selects octal.
            n_phase = PH_DIGITS;
            n_octal = 1'b1;
        end else if (is_digit) begin
            n_phase = PH_DIGITS;
            if (in_limit) begin
                // A digit that passes the limit check can still overflow.
                if (|mag_new[MAG_W+3:MAG_W]) begin
                    n_ovf = 1'b1;
                end
                n_mag = mag_new[MAG_W-1:0];
            end else begin
                n_ovf = 1'b1;
            end
            if (r_octal) begin
                if (r_obits == '0) begin
                    if (i_char == CH_ONE) begin
                        n_obits = 6'd1;
                    end else if (i_char == CH_TWO || i_char == CH_THREE) begin
                        n_obits = 6'd2;
                    end else if (i_char != CH_ZERO) begin
                        n_obits = 6'd3;
                    end
                end else begin
                    n_obits = (r_obits > OBITS_LIMIT) ? OBITS_SAT : (r_obits + OBITS_STEP);
                end
            end
        end else begin
            // Any other character ends the number.
            emit = 1'b1;
            if (bad_term) begin
                res.status = ST_GARBAGE;
            end else if (r_ovf) begin
                if (r_obits == '0) begin
                    res.status = ST_GARBAGE;
                end else begin
                    res.bit_count = BITCNT_W'(r_obits) + BITCNT_W'(r_neg);
                    res.status    = ST_OVERSIZE;
                end
            end else begin
                res.value = r_neg ? mag_neg[VALUE_W-1:0] : mag_ext[VALUE_W-1:0];
            end
            n_phase = PH_START;
            n_neg   = 1'b0;
            n_octal = 1'b0;
            n_mag   = '0;
            n_ovf   = 1'b0;
            n_obits = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term  <= TERM_RESET;
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_octal <= 1'b0;
            r_mag   <= '0;
            r_ovf   <= 1'b0;
            r_obits <= '0;
        end else begin
            if (i_cfg_we) begin
                r_term <= i_cfg_term;
            end
            if (i_step) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_octal <= n_octal;
                r_mag   <= n_mag;
                r_ovf   <= n_ovf;
                r_obits <= n_obits;
            end
        end
    end

    assign o_emit   = emit;
    assign o_result = res;

endmodule

`default_nettype wire

// ----- rtl/ans_out_stage.sv -----
`default_nettype none

module ans_out_stage import ans_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_ready,
    output logic         o_valid,
    output t_result      o_result
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- rtl/ascii_number_scanner.sv -----
// ascii_number_scanner: scans signed decimal or octal integer literals from
// a stream of ASCII characters, one character per request on i_char.
// A number may start with a minus sign; a leading zero selects octal.
// The first character that is not a digit ends the number and produces one
// request on o_result carrying value, bit_count and status. Digits and the
// sign produce no result.
// The terminator register is written through i_cfg, whose ready is always
// high; it should be written only while the scanner is idle.
// A character is captured in the input register, and the scan logic then
// updates its state from it and loads the result register. Throughput is
// one character per cycle while no character that ends a number waits for
// the result register. The state update shifts and adds the magnitude.
// When the receiver stalls, a waiting result stays in the result register;
// characters that end no number keep flowing, and a character that ends a
// number waits in the input register until the result register frees.
// Synchronous active-low reset empties both registers, clears the scan
// state and sets the terminator to a semicolon.
`default_nettype none

module ascii_number_scanner import ans_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ans_cfg_if.sink    i_cfg,
    ans_char_if.sink   i_char,
    ans_result_if.source o_result
);

    logic              in_valid;
    logic [CHAR_W-1:0] in_char;
    logic              in_ready;
    logic              core_emit;
    t_result           core_result;
    logic              out_valid;
    t_result           out_result;
    logic              adv;
    logic              load_out;

    // The registered character is consumed when it produces no result or
    // when the result register is empty or being drained this cycle.
    assign adv      = in_valid && (!core_emit || !out_valid || o_result.ready);
    assign load_out = adv && core_emit;

    assign i_cfg.ready  = 1'b1;
    assign i_char.ready = in_ready;

    ans_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_char.valid),
        .i_char  (i_char.char_in),
        .i_adv   (adv),
        .o_ready (in_ready),
        .o_valid (in_valid),
        .o_char  (in_char)
    );

    ans_scan_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_term (i_cfg.terminator_char),
        .i_step     (adv),
        .i_char     (in_char),
        .o_emit     (core_emit),
        .o_result   (core_result)
    );

    ans_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load_out),
        .i_result (core_result),
        .i_ready  (o_result.ready),
        .o_valid  (out_valid),
        .o_result (out_result)
    );

    assign o_result.valid     = out_valid;
    assign o_result.value     = out_result.value;
    assign o_result.bit_count = out_result.bit_count;
    assign o_result.status    = out_result.status;

`ifndef SYNTHESIS
    // A new result never overwrites one that the receiver has not taken.
    a_no_overwrite : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!out_valid || o_result.ready))
        else $error("result register overwritten while stalled");

    // Only an ok status carries a nonzero value.
    a_value_only_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_result.status != ST_OK) |-> (out_result.value == '0))
        else $error("nonzero value with non-ok status");

    // A bit count appears exactly with the oversized status.
    a_bitcount_oversize : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> ((out_result.bit_count != '0) == (out_result.status == ST_OVERSIZE)))
        else $error("bit count and oversized status disagree");

    // A stalled input register holds while the core is not consuming it.
    a_in_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && !adv) |=> (in_valid && $stable(in_char)))
        else $error("input register lost an unconsumed character");
`endif

endmodule

`default_nettype wire
